FILE: rtl/core/qnl_pkg.sv
// qnl_pkg: shared constants and stage structs for the quaternion nlerp core
// no dependencies; used by the interfaces, qnl_blend and quaternion_nlerp (not by qnl_isqrt or qnl_div)

package qnl_pkg;

   localparam int COMPONENT_WIDTH_DEF = 16;
   localparam int T_W = 17;
   localparam logic [T_W-1:0] T_ONE = 17'h10000;
   localparam int NORM_FRAC = 30;
   localparam int OUT_FRAC = 14;
   localparam int OUT_W = 16;
   localparam int NMAG_W = NORM_FRAC + 1;
   localparam int NSIG_W = NMAG_W + 1;
   localparam int CMAG_W = 31;
   localparam int SUMSQ_W = 64;
   localparam int BROOT_W = SUMSQ_W / 2;
   localparam int OQ_W = OUT_FRAC + 1;
   localparam logic [SUMSQ_W-1:0] BLEND_EPS_SQ = 64'd16384;

   typedef struct packed {
      logic valid;
      logic zero;
      logic [T_W-1:0] t;
      logic [3:0] src_neg;
      logic [3:0][NMAG_W-1:0] src_mag;
      logic [3:0] dst_neg;
      logic [3:0][NMAG_W-1:0] dst_mag;
   } blend_in_type;

   typedef struct packed {
      logic valid;
      logic deg;
      logic [3:0] c_neg;
      logic [3:0][CMAG_W-1:0] c_mag;
      logic [SUMSQ_W-1:0] sum_sq;
   } blend_out_type;

endpackage

FILE: rtl/core/qnl_req_if.sv
// qnl_req_if: request channel, source and target quaternion plus blend fraction
// depends on qnl_pkg for widths

interface qnl_req_if #(parameter int COMPONENT_WIDTH = qnl_pkg::COMPONENT_WIDTH_DEF);
   logic valid;
   logic ready;
   logic signed [COMPONENT_WIDTH-1:0] src_w;
   logic signed [COMPONENT_WIDTH-1:0] src_x;
   logic signed [COMPONENT_WIDTH-1:0] src_y;
   logic signed [COMPONENT_WIDTH-1:0] src_z;
   logic signed [COMPONENT_WIDTH-1:0] dst_w;
   logic signed [COMPONENT_WIDTH-1:0] dst_x;
   logic signed [COMPONENT_WIDTH-1:0] dst_y;
   logic signed [COMPONENT_WIDTH-1:0] dst_z;
   logic [qnl_pkg::T_W-1:0] blend_t;

   modport source (output valid, output src_w, output src_x, output src_y, output src_z,
                   output dst_w, output dst_x, output dst_y, output dst_z,
                   output blend_t, input ready);
   modport sink (input valid, input src_w, input src_x, input src_y, input src_z,
                 input dst_w, input dst_x, input dst_y, input dst_z,
                 input blend_t, output ready);
endinterface

FILE: rtl/core/qnl_rsp_if.sv
// qnl_rsp_if: response channel, blended unit quaternion and degenerate flag
// depends on qnl_pkg for widths

interface qnl_rsp_if;
   logic valid;
   logic ready;
   logic signed [qnl_pkg::OUT_W-1:0] out_w;
   logic signed [qnl_pkg::OUT_W-1:0] out_x;
   logic signed [qnl_pkg::OUT_W-1:0] out_y;
   logic signed [qnl_pkg::OUT_W-1:0] out_z;
   logic degenerate;

   modport source (output valid, output out_w, output out_x, output out_y, output out_z,
                   output degenerate, input ready);
   modport sink (input valid, input out_w, input out_x, input out_y, input out_z,
                 input degenerate, output ready);
endinterface

FILE: rtl/core/qnl_isqrt.sv
// qnl_isqrt: pipelined integer square root, one root bit per stage
// generic; carries a sideband word alongside each operand

module qnl_isqrt #(
   parameter int ROOT_W = 17,
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   radicand,
   input  logic [SIDE_W-1:0]     side_in,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     root,
   output logic [SIDE_W-1:0]     side_out
);
   localparam int REM_W = ROOT_W + 2;
   localparam int RAD_W = 2 * ROOT_W;

   logic [ROOT_W-1:0] valid_ff;
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      logic              valid_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [REM_W-1:0]  rem_try;
      logic [REM_W-1:0]  trial;
      logic              fits;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [RAD_W-1:0]  rad_in;

      if (j == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign rad_prev   = radicand;
         assign side_prev  = side_in;
      end else begin : g_next
         assign valid_prev = valid_ff[j-1];
         assign rem_prev   = rem_ff[j-1];
         assign root_prev  = root_ff[j-1];
         assign rad_prev   = rad_ff[j-1];
         assign side_prev  = side_ff[j-1];
      end

      assign rem_try = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
      assign trial   = {root_prev, 2'b01};
      assign fits    = (rem_try >= trial);
      assign rem_in  = fits ? (rem_try - trial) : rem_try;
      assign root_in = {root_prev[ROOT_W-2:0], fits};
      assign rad_in  = {rad_prev[RAD_W-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            rad_ff[j]  <= rad_in;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];
   assign side_out  = side_ff[ROOT_W-1];

endmodule

FILE: rtl/core/qnl_div.sv
// qnl_div: pipelined restoring divider, one quotient bit per stage
// generic; needs num < den * 2^QUO_W; carries a sideband word

module qnl_div #(
   parameter int DEN_W  = 17,
   parameter int QUO_W  = 31,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [DEN_W+QUO_W-1:0]   num,
   input  logic [DEN_W-1:0]         den,
   input  logic [SIDE_W-1:0]        side_in,
   output logic                     out_valid,
   output logic [QUO_W-1:0]         quo,
   output logic [SIDE_W-1:0]        side_out
);
   localparam int NUM_W = DEN_W + QUO_W;

   logic [QUO_W-1:0]  valid_ff;
   logic [DEN_W-1:0]  rem_ff  [QUO_W];
   logic [QUO_W-1:0]  low_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      logic              valid_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [QUO_W-1:0]  low_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    rem_try;
      logic [DEN_W:0]    rem_sub;
      logic              fits;
      logic [DEN_W-1:0]  rem_in;
      logic [QUO_W-1:0]  low_in;

      if (j == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = num[NUM_W-1:QUO_W];
         assign low_prev   = num[QUO_W-1:0];
         assign den_prev   = den;
         assign side_prev  = side_in;
      end else begin : g_next
         assign valid_prev = valid_ff[j-1];
         assign rem_prev   = rem_ff[j-1];
         assign low_prev   = low_ff[j-1];
         assign den_prev   = den_ff[j-1];
         assign side_prev  = side_ff[j-1];
      end

      assign rem_try = {rem_prev, low_prev[QUO_W-1]};
      assign fits    = (rem_try >= {1'b0, den_prev});
      assign rem_sub = rem_try - {1'b0, den_prev};
      assign rem_in  = fits ? rem_sub[DEN_W-1:0] : rem_try[DEN_W-1:0];
      assign low_in  = {low_prev[QUO_W-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            low_ff[j]  <= low_in;
            den_ff[j]  <= den_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign quo       = low_ff[QUO_W-1];
   assign side_out  = side_ff[QUO_W-1];

endmodule

FILE: rtl/core/qnl_blend.sv
// qnl_blend: shortest-path sign fix, linear blend and blend sum of squares
// six register stages; depends on qnl_pkg

module qnl_blend (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  qnl_pkg::blend_in_type  blend_in,
   output qnl_pkg::blend_out_type blend_out
);
   import qnl_pkg::*;

   localparam int DOT_W = 2 * NSIG_W;
   localparam int BL_W  = NSIG_W + T_W + 1;
   localparam int BS_W  = BL_W + 1;
   localparam int CSQ_W = 2 * CMAG_W;

   logic [5:0] valid_ff;
   logic [5:0] zero_ff;

   // stage 1: signed operands and dot terms
   logic signed [3:0][NSIG_W-1:0] ns1_in, nd1_in, ns1_ff, nd1_ff;
   logic signed [3:0][DOT_W-1:0]  dp1_in, dp1_ff;
   logic [T_W-1:0]                t1_ff;
   // stage 2: dot sign
   logic signed [DOT_W-1:0]       dot2;
   logic                          flip2_ff;
   logic signed [3:0][NSIG_W-1:0] ns2_ff, nd2_ff;
   logic [T_W-1:0]                t2_ff;
   // stage 3: blend products
   logic [T_W-1:0]                om3;
   logic signed [3:0][BL_W-1:0]   pa3_in, pb3_in, pa3_ff, pb3_ff;
   // stage 4: rounded blend magnitude
   logic signed [3:0][BS_W-1:0]   b4;
   logic [3:0][BS_W-1:0]          bm4, rnd4;
   logic [3:0][CMAG_W-1:0]        c4_in, c4_ff;
   logic [3:0]                    cn4_in, cn4_ff;
   // stage 5: squares
   logic [3:0][CSQ_W-1:0]         sq5_in, sq5_ff;
   logic [3:0][CMAG_W-1:0]        c5_ff;
   logic [3:0]                    cn5_ff;
   // stage 6: sum and degenerate check
   logic [SUMSQ_W-1:0]            sum6_in, sum6_ff;
   logic [3:0][CMAG_W-1:0]        c6_ff;
   logic [3:0]                    cn6_ff;
   logic                          deg6_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         ns1_in[k] = blend_in.src_neg[k] ? -NSIG_W'({1'b0, blend_in.src_mag[k]})
                                         :  NSIG_W'({1'b0, blend_in.src_mag[k]});
         nd1_in[k] = blend_in.dst_neg[k] ? -NSIG_W'({1'b0, blend_in.dst_mag[k]})
                                         :  NSIG_W'({1'b0, blend_in.dst_mag[k]});
         dp1_in[k] = DOT_W'(signed'(ns1_in[k])) * DOT_W'(signed'(nd1_in[k]));
      end
   end

   assign dot2 = signed'(dp1_ff[0]) + signed'(dp1_ff[1]) + signed'(dp1_ff[2])
               + signed'(dp1_ff[3]);

   assign om3 = T_ONE - t2_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pa3_in[k] = BL_W'(signed'(ns2_ff[k])) * BL_W'(signed'({1'b0, om3}));
         pb3_in[k] = (flip2_ff ? -BL_W'(signed'(nd2_ff[k])) : BL_W'(signed'(nd2_ff[k])))
                   * BL_W'(signed'({1'b0, t2_ff}));
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         b4[k]     = BS_W'(signed'(pa3_ff[k])) + BS_W'(signed'(pb3_ff[k]));
         cn4_in[k] = b4[k][BS_W-1];
         bm4[k]    = cn4_in[k] ? BS_W'(-b4[k]) : BS_W'(b4[k]);
         rnd4[k]   = bm4[k] + BS_W'(32768);
         c4_in[k]  = rnd4[k][CMAG_W+15:16];
         sq5_in[k] = CSQ_W'(c4_ff[k]) * CSQ_W'(c4_ff[k]);
      end
   end

   assign sum6_in = SUMSQ_W'(sq5_ff[0]) + SUMSQ_W'(sq5_ff[1]) + SUMSQ_W'(sq5_ff[2])
                  + SUMSQ_W'(sq5_ff[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[4:0], blend_in.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff  <= {zero_ff[4:0], blend_in.zero};
         ns1_ff   <= ns1_in;
         nd1_ff   <= nd1_in;
         dp1_ff   <= dp1_in;
         t1_ff    <= blend_in.t;
         flip2_ff <= dot2[DOT_W-1];
         ns2_ff   <= ns1_ff;
         nd2_ff   <= nd1_ff;
         t2_ff    <= t1_ff;
         pa3_ff   <= pa3_in;
         pb3_ff   <= pb3_in;
         c4_ff    <= c4_in;
         cn4_ff   <= cn4_in;
         sq5_ff   <= sq5_in;
         c5_ff    <= c4_ff;
         cn5_ff   <= cn4_ff;
         sum6_ff  <= sum6_in;
         c6_ff    <= c5_ff;
         cn6_ff   <= cn5_ff;
         deg6_ff  <= zero_ff[4] || (sum6_in <= BLEND_EPS_SQ);
      end
   end

   assign blend_out.valid  = valid_ff[5];
   assign blend_out.deg    = deg6_ff || zero_ff[5];
   assign blend_out.c_neg  = cn6_ff;
   assign blend_out.c_mag  = c6_ff;
   assign blend_out.sum_sq = sum6_ff;

endmodule

FILE: rtl/core/quaternion_nlerp.sv
// quaternion_nlerp: fixed point quaternion nlerp, one transfer per cycle while the output is not stalled
// the three square roots and twelve dividers are bit-per-stage pipelines and set most of the depth
// stalls hold the whole pipe; the input register still fills while the output waits
// synchronous reset clears all valid bits; no state survives between items
// depends on qnl_pkg, qnl_req_if, qnl_rsp_if, qnl_isqrt, qnl_div, qnl_blend

module quaternion_nlerp #(
   parameter int COMPONENT_WIDTH = qnl_pkg::COMPONENT_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   qnl_req_if.sink    req_ch,
   qnl_rsp_if.source  rsp_ch
);
   import qnl_pkg::*;

   localparam int W       = COMPONENT_WIDTH;
   localparam int SQ_W    = 2 * W;
   localparam int NROOT_W = W + 1;
   localparam int SUM_W   = 2 * NROOT_W;
   localparam int NNUM_W  = NROOT_W + NMAG_W;
   localparam int QSIDE_W = 4 * W + 4;
   localparam int NSIDE_W = T_W + 2;
   localparam int BSIDE_W = 1 + 4 + 4 * CMAG_W;
   localparam int ONUM_W  = BROOT_W + OQ_W;

   logic adv, ld_in;

   // input register
   logic                   in_valid_ff;
   logic signed [7:0][W-1:0] comp_in, comp_ff;
   logic [T_W-1:0]         t_in, t_ff;
   // magnitudes and squares
   logic                   sq_valid_ff;
   logic [7:0][W-1:0]      mag2_in, mag2_ff;
   logic [7:0]             neg2_ff;
   logic [7:0][SQ_W-1:0]   sq2_in, sq2_ff;
   logic [T_W-1:0]         t2_ff;
   // sums of squares
   logic                   sum_valid_ff;
   logic [1:0][SUM_W-1:0]  sum3_in, sum3_ff;
   logic                   zero3_ff;
   logic [7:0][W-1:0]      mag3_ff;
   logic [7:0]             neg3_ff;
   logic [T_W-1:0]         t3_ff;
   // input norms
   logic                   src_rv, dst_rv;
   logic [NROOT_W-1:0]     src_root, dst_root;
   logic [QSIDE_W-1:0]     src_side, dst_side_q;
   logic [QSIDE_W+T_W:0]   dst_side;
   logic [3:0][W-1:0]      smag_r, dmag_r;
   logic [3:0]             sneg_r, dneg_r;
   logic [T_W-1:0]         t_r;
   logic                   zero_r;
   logic [7:0][W-1:0]      nmag_r;
   logic [7:0]             nneg_r;
   logic [1:0][NROOT_W-1:0] nroot_r;
   // normalized components
   logic [7:0]             ndv;
   logic [7:0][NMAG_W-1:0] nq;
   logic [7:0][NSIDE_W-1:0] nside;
   blend_in_type           blend_in;
   blend_out_type          blend_out;
   // blend norm and output division
   logic                   bm_valid;
   logic [BROOT_W-1:0]     bm_root;
   logic [BSIDE_W-1:0]     bm_side;
   logic                   bm_deg;
   logic [3:0]             bm_neg;
   logic [3:0][CMAG_W-1:0] bm_mag;
   logic [3:0]             odv;
   logic [3:0][OQ_W-1:0]   oq;
   logic [3:0][1:0]        oside;
   // output register
   logic                   rsp_valid_ff;
   logic signed [3:0][OUT_W-1:0] out_in, out_ff;
   logic                   deg_ff;

   assign adv   = !rsp_valid_ff || rsp_ch.ready;
   assign ld_in = adv || !in_valid_ff;
   assign req_ch.ready = ld_in;

   assign comp_in = {req_ch.dst_z, req_ch.dst_y, req_ch.dst_x, req_ch.dst_w,
                     req_ch.src_z, req_ch.src_y, req_ch.src_x, req_ch.src_w};
   assign t_in = (req_ch.blend_t > T_ONE) ? T_ONE : req_ch.blend_t;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         mag2_in[k] = comp_ff[k][W-1] ? W'(-comp_ff[k]) : W'(comp_ff[k]);
         sq2_in[k]  = SQ_W'(mag2_in[k]) * SQ_W'(mag2_in[k]);
      end
      for (int h = 0; h < 2; h++) begin
         sum3_in[h] = SUM_W'(sq2_ff[4*h]) + SUM_W'(sq2_ff[4*h+1])
                    + SUM_W'(sq2_ff[4*h+2]) + SUM_W'(sq2_ff[4*h+3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (ld_in) begin
            in_valid_ff <= req_ch.valid;
         end
         if (adv) begin
            sq_valid_ff  <= in_valid_ff;
            sum_valid_ff <= sq_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld_in) begin
         comp_ff <= comp_in;
         t_ff    <= t_in;
      end
      if (adv) begin
         mag2_ff  <= mag2_in;
         for (int k = 0; k < 8; k++) begin
            neg2_ff[k] <= comp_ff[k][W-1];
         end
         sq2_ff   <= sq2_in;
         t2_ff    <= t_ff;
         sum3_ff  <= sum3_in;
         zero3_ff <= (sum3_in[0] == '0) || (sum3_in[1] == '0);
         mag3_ff  <= mag2_ff;
         neg3_ff  <= neg2_ff;
         t3_ff    <= t2_ff;
      end
   end

   qnl_isqrt #(.ROOT_W(NROOT_W), .SIDE_W(QSIDE_W)) u_src_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sum_valid_ff),
      .radicand  (sum3_ff[0]),
      .side_in   ({neg3_ff[3:0], mag3_ff[3:0]}),
      .out_valid (src_rv),
      .root      (src_root),
      .side_out  (src_side)
   );

   qnl_isqrt #(.ROOT_W(NROOT_W), .SIDE_W(QSIDE_W + T_W + 1)) u_dst_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sum_valid_ff),
      .radicand  (sum3_ff[1]),
      .side_in   ({zero3_ff, t3_ff, neg3_ff[7:4], mag3_ff[7:4]}),
      .out_valid (dst_rv),
      .root      (dst_root),
      .side_out  (dst_side)
   );

   assign {sneg_r, smag_r} = src_side;
   assign {zero_r, t_r, dst_side_q} = dst_side;
   assign {dneg_r, dmag_r} = dst_side_q;
   assign nmag_r  = {dmag_r, smag_r};
   assign nneg_r  = {dneg_r, sneg_r};
   assign nroot_r = {dst_root, src_root};

   for (genvar k = 0; k < 8; k++) begin : g_norm_div
      logic [NNUM_W-1:0] num;
      assign num = NNUM_W'({nmag_r[k], {NORM_FRAC{1'b0}}})
                 + NNUM_W'(nroot_r[k >> 2] >> 1);

      qnl_div #(.DEN_W(NROOT_W), .QUO_W(NMAG_W), .SIDE_W(NSIDE_W)) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (src_rv && dst_rv),
         .num       (num),
         .den       (nroot_r[k >> 2]),
         .side_in   ({zero_r, t_r, nneg_r[k]}),
         .out_valid (ndv[k]),
         .quo       (nq[k]),
         .side_out  (nside[k])
      );
   end

   always_comb begin
      blend_in.valid = ndv[0];
      blend_in.zero  = nside[0][NSIDE_W-1];
      blend_in.t     = nside[0][T_W:1];
      for (int k = 0; k < 4; k++) begin
         blend_in.src_neg[k] = nside[k][0];
         blend_in.src_mag[k] = nq[k];
         blend_in.dst_neg[k] = nside[k+4][0];
         blend_in.dst_mag[k] = nq[k+4];
      end
   end

   qnl_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .blend_in  (blend_in),
      .blend_out (blend_out)
   );

   qnl_isqrt #(.ROOT_W(BROOT_W), .SIDE_W(BSIDE_W)) u_blend_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (blend_out.valid),
      .radicand  (blend_out.sum_sq),
      .side_in   ({blend_out.deg, blend_out.c_neg, blend_out.c_mag}),
      .out_valid (bm_valid),
      .root      (bm_root),
      .side_out  (bm_side)
   );

   assign {bm_deg, bm_neg, bm_mag} = bm_side;

   for (genvar k = 0; k < 4; k++) begin : g_out_div
      logic [ONUM_W-1:0] num;
      assign num = ONUM_W'({bm_mag[k], {OUT_FRAC{1'b0}}}) + ONUM_W'(bm_root >> 1);

      qnl_div #(.DEN_W(BROOT_W), .QUO_W(OQ_W), .SIDE_W(2)) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (bm_valid),
         .num       (num),
         .den       (bm_root),
         .side_in   ({bm_deg, bm_neg[k]}),
         .out_valid (odv[k]),
         .quo       (oq[k]),
         .side_out  (oside[k])
      );
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (oside[0][1]) begin
            out_in[k] = '0;
         end else if (oside[k][0]) begin
            out_in[k] = -OUT_W'(oq[k]);
         end else begin
            out_in[k] = OUT_W'(oq[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= odv[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
         deg_ff <= oside[0][1];
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_w      = out_ff[0];
   assign rsp_ch.out_x      = out_ff[1];
   assign rsp_ch.out_y      = out_ff[2];
   assign rsp_ch.out_z      = out_ff[3];
   assign rsp_ch.degenerate = deg_ff;

endmodule

FILE: tb/sv/tb_qnl_if.sv
// tb_qnl_if: request and response item types shared by the testbench top
// depends on qnl_pkg; channel interfaces come from the rtl files qnl_req_if and qnl_rsp_if

package tb_qnl_pkg;
   import qnl_pkg::*;

   typedef struct {
      logic signed [15:0] comp [8];
      logic [T_W-1:0] blend_t;
   } nlerp_req_type;

   typedef struct {
      logic signed [OUT_W-1:0] q [4];
      logic deg;
   } nlerp_rsp_type;
endpackage

FILE: tb/sv/tb.sv
// tb: self-checking testbench for quaternion_nlerp, random and directed quaternion pairs
// depends on qnl_pkg, tb_qnl_pkg, qnl_req_if, qnl_rsp_if and the rtl of the block

module tb;
   import qnl_pkg::*;
   import tb_qnl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit failed = 1'b0;
   bit stim_done = 1'b0;
   int hold_cycles = 0;

   qnl_req_if #(.COMPONENT_WIDTH(16)) req_ch ();
   qnl_rsp_if rsp_ch ();

   quaternion_nlerp #(.COMPONENT_WIDTH(16)) i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   nlerp_req_type pending_reqs[$];
   nlerp_rsp_type expected_blends[$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint unsigned isqrt64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic bit unit_q(input logic signed [15:0] c [4], output longint n [4]);
      longint unsigned mag [4];
      longint unsigned sum, nrm, q;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
         mag[i] = c[i] < 0 ? -longint'(c[i]) : longint'(c[i]);
         sum += mag[i] * mag[i];
      end
      if (sum == 0) return 1'b0;
      nrm = isqrt64(sum);
      for (int i = 0; i < 4; i++) begin
         q = ((mag[i] << NORM_FRAC) + (nrm >> 1)) / nrm;
         n[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic nlerp_rsp_type predict_blend(nlerp_req_type r);
      nlerp_rsp_type res;
      logic signed [15:0] s [4], d [4];
      longint ns [4], nd [4], dot, b;
      longint unsigned t, cm [4], sq, m, q, bm;
      bit cn [4];
      for (int i = 0; i < 4; i++) begin
         s[i] = r.comp[i];
         d[i] = r.comp[i+4];
         res.q[i] = '0;
      end
      res.deg = 1'b1;
      t = r.blend_t > T_ONE ? 65536 : r.blend_t;
      if (!unit_q(s, ns) || !unit_q(d, nd)) return res;
      dot = 0;
      for (int i = 0; i < 4; i++) dot += ns[i] * nd[i];
      if (dot < 0) for (int i = 0; i < 4; i++) nd[i] = -nd[i];
      sq = 0;
      for (int i = 0; i < 4; i++) begin
         b = ns[i] * longint'(65536 - t) + nd[i] * longint'(t);
         cn[i] = b < 0;
         bm = b < 0 ? -b : b;
         cm[i] = (bm + (64'd1 << 15)) >> 16;
         sq += cm[i] * cm[i];
      end
      if (sq <= BLEND_EPS_SQ) return res;
      m = isqrt64(sq);
      for (int i = 0; i < 4; i++) begin
         q = ((cm[i] << OUT_FRAC) + (m >> 1)) / m;
         res.q[i] = cn[i] ? OUT_W'(-longint'(q)) : OUT_W'(longint'(q));
      end
      res.deg = 1'b0;
      return res;
   endfunction

   function automatic logic signed [15:0] rand_comp(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 16)) - 16'sd8;
         2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return 16'($urandom_range(0, 8192)) - 16'sd4096;
      endcase
   endfunction

   task automatic add_req(input logic signed [15:0] c [8], input int t);
      nlerp_req_type r;
      r.comp = c;
      r.blend_t = T_W'(t);
      pending_reqs.push_back(r);
   endtask

   initial begin
      logic signed [15:0] c [8];
      int tv [5];
      tv = '{0, 1, 32768, 65536, 131071};
      foreach (tv[k]) begin
         c = '{16'sd4096, 0, 0, 0, 0, 16'sd4096, 0, 0};
         add_req(c, tv[k]);
      end
      c = '{0, 0, 0, 0, 16'sd100, 16'sd5, 0, 0};
      add_req(c, 30000);
      c = '{16'sd100, 16'sd5, 0, 0, 0, 0, 0, 0};
      add_req(c, 30000);
      c = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
            16'sh8000, 16'sh8000};
      add_req(c, 32768);
      c = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
            16'sh7fff, 16'sh7fff};
      add_req(c, 65535);
      c = '{16'sd1, 0, 0, 0, -16'sd1, 0, 0, 0};
      add_req(c, 32768);
      c = '{16'sd1, 16'sd2, -16'sd3, 16'sd4, 16'sd3, -16'sd1, 16'sd1, 16'sd1};
      add_req(c, 32768);
      c = '{16'sd3, 0, 0, 0, 0, -16'sd7, 0, 0};
      add_req(c, 98304);
      for (int n = 0; n < 1250; n++) begin
         int mode;
         mode = $urandom_range(0, 3);
         for (int k = 0; k < 8; k++) c[k] = rand_comp(mode);
         if ($urandom_range(0, 40) == 0) for (int k = 0; k < 4; k++) c[k] = 0;
         if ($urandom_range(0, 40) == 0) for (int k = 4; k < 8; k++) c[k] = 0;
         if ($urandom_range(0, 20) == 0) for (int k = 0; k < 4; k++) c[k+4] = -c[k];
         case ($urandom_range(0, 5))
            0: add_req(c, $urandom_range(65536, 131071));
            1: add_req(c, $urandom_range(0, 1) ? 0 : 65536);
            default: add_req(c, $urandom_range(0, 65536));
         endcase
      end
      stim_done = 1'b1;
   end

   // request transfer seen at the rising edge, acted on at the falling edge
   bit req_seen = 1'b0;
   int req_gap = 0;
   always @(posedge clock) begin
      req_seen <= !reset && req_ch.valid && req_ch.ready;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_seen) begin
            expected_blends.push_back(predict_blend(pending_reqs.pop_front()));
            req_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0;
         end
         if (!req_ch.valid || req_seen) begin
            if (req_gap > 0 || pending_reqs.size() == 0) begin
               if (req_gap > 0) req_gap--;
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.valid <= 1'b1;
               req_ch.src_w <= pending_reqs[0].comp[0];
               req_ch.src_x <= pending_reqs[0].comp[1];
               req_ch.src_y <= pending_reqs[0].comp[2];
               req_ch.src_z <= pending_reqs[0].comp[3];
               req_ch.dst_w <= pending_reqs[0].comp[4];
               req_ch.dst_x <= pending_reqs[0].comp[5];
               req_ch.dst_y <= pending_reqs[0].comp[6];
               req_ch.dst_z <= pending_reqs[0].comp[7];
               req_ch.blend_t <= pending_reqs[0].blend_t;
            end
         end
      end
   end

   // transfer checked at rising edge, ready changed at falling edge
   bit rsp_seen = 1'b0;
   int rsp_gap = 0;
   int rsp_count = 0;
   always @(posedge clock) begin
      nlerp_rsp_type exp_r;
      rsp_seen <= !reset && rsp_ch.valid && rsp_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_count++;
         if (expected_blends.size() == 0) begin
            $display("%0t: unexpected transfer w=%0d x=%0d y=%0d z=%0d deg=%0b", $realtime,
                     rsp_ch.out_w, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z,
                     rsp_ch.degenerate);
            failed = 1'b1;
         end else begin
            exp_r = expected_blends.pop_front();
            if (rsp_ch.out_w !== exp_r.q[0] || rsp_ch.out_x !== exp_r.q[1] ||
                rsp_ch.out_y !== exp_r.q[2] || rsp_ch.out_z !== exp_r.q[3] ||
                rsp_ch.degenerate !== exp_r.deg) begin
               $display("%0t: mismatch expected %0d %0d %0d %0d deg=%0b %s",
                        $realtime, exp_r.q[0], exp_r.q[1], exp_r.q[2], exp_r.q[3],
                        exp_r.deg, "actual");
               $display("   %0d %0d %0d %0d deg=%0b",
                        rsp_ch.out_w, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z,
                        rsp_ch.degenerate);
               failed = 1'b1;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_count == 300 && rsp_seen) begin
         hold_cycles = 400;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_seen && $urandom_range(0, 3) == 0) rsp_gap = $urandom_range(0, 12);
         rsp_ch.ready <= !(rsp_seen && rsp_gap > 0);
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.src_w = '0; req_ch.src_x = '0; req_ch.src_y = '0; req_ch.src_z = '0;
      req_ch.dst_w = '0; req_ch.dst_x = '0; req_ch.dst_y = '0; req_ch.dst_z = '0;
      req_ch.blend_t = '0;
      rsp_ch.ready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      wait (stim_done && pending_reqs.size() == 0 && !req_ch.valid);
      wait (expected_blends.size() == 0);
      repeat (300) @(posedge clock);
      if (!failed) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #1ms;
      $display("FAILURE");
      $finish;
   end
endmodule
